/* design/flipper_coil_power_hold_control_unit_defines.svh */
// Assertion macros shared by the flipper coil control design
`ifndef FLIPPER_COIL_POWER_HOLD_CONTROL_UNIT_DEFINES_SVH
`define FLIPPER_COIL_POWER_HOLD_CONTROL_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off while in reset
`define FCPHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while in reset
`define FCPHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/fcphc_pkg.sv */
// Types and constants for the flipper coil power/hold controller
package fcphc_pkg;

  localparam int unsigned NUM_FLIP    = 4;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned SW_W        = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CNT_W-1:0] LIMIT_RST = 8'd10;
  localparam logic [CNT_W-1:0] CNT_MAX   = 8'd255;

  // Flipper slots: counter index and coil bit pair
  localparam int unsigned SLOT_LR = 0;
  localparam int unsigned SLOT_LL = 1;
  localparam int unsigned SLOT_UR = 2;
  localparam int unsigned SLOT_UL = 3;

  // Switch bit positions (active high after inversion)
  localparam int unsigned SW_LR_EOS = 0;
  localparam int unsigned SW_LR_BTN = 1;
  localparam int unsigned SW_LL_EOS = 2;
  localparam int unsigned SW_LL_BTN = 3;
  localparam int unsigned SW_UR_EOS = 4;
  localparam int unsigned SW_UR_BTN = 5;
  localparam int unsigned SW_UL_EOS = 6;
  localparam int unsigned SW_UL_BTN = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLIPPERS_ON  = 3'd0,
    REG_POWER_LIMIT  = 3'd1,
    REG_GUN_HANDLES  = 3'd2,
    REG_UL_PRESENT   = 3'd3,
    REG_UR_PRESENT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic             flippers_on;
    logic [CNT_W-1:0] power_limit;
    logic             gun_handles;
    logic             ul_present;
    logic             ur_present;
  } cfg_regs_t;

  typedef struct packed {
    logic step;
    logic clear_all;
    logic serve;
    logic pressed;
    logic eos;
  } flip_ctl_t;

  typedef struct packed {
    logic hold;
    logic power;
  } coil_pair_t;

endpackage

/* design/flipper_coil_power_hold_control_unit.sv */
// Top level of the flipper coil power/hold controller
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata[23:0]: switches, override, extra bits
//  out_    | out | out_tvalid/tready  | out_tdata[7:0]: coil drive
//  cfg_    | in  | cfg_valid/ready    | cfg_index[2:0], cfg_data[7:0]
//
// One item per cycle sustained while the output is not stalled; an accepted item passes
// through the input register, is evaluated against the four power counters and lands in
// the output register in the same cycle as the counters update.
// Reset (rst_n low, synchronous) empties both registers, clears counters, loads config defaults.
// Output stall holds the output; the input register keeps accepting until it is full.
`include "flipper_coil_power_hold_control_unit_defines.svh"
module flipper_coil_power_hold_control_unit
  import fcphc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // switch_lines, override_mask, extra_coil_bits
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // coil_drive
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t        regs;
  logic             stg_valid_r;
  logic [23:0]      stg_data_r;
  logic             out_valid_r;
  logic [SW_W-1:0]  out_data_r;
  logic             adv;
  logic [SW_W-1:0]  sw, ovr, extra, act;
  logic             act_any, clear_all;
  logic [NUM_FLIP-1:0] pressed, eos, present;
  flip_ctl_t        ctl [NUM_FLIP];
  coil_pair_t       coil [NUM_FLIP];
  logic [SW_W-1:0]  drive;

  fcphc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  assign adv       = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_data_r <= in_tdata;
    end
  end

  assign sw        = stg_data_r[7:0];
  assign ovr       = stg_data_r[15:8];
  assign extra     = stg_data_r[23:16];
  assign act       = ~sw | ovr;
  assign act_any   = |act;
  assign clear_all = regs.flippers_on && !act_any;

  always_comb begin
    pressed[SLOT_LR] = act[SW_LR_BTN] || (regs.gun_handles && act[SW_UR_BTN]);
    pressed[SLOT_LL] = act[SW_LL_BTN] || (regs.gun_handles && act[SW_UL_BTN]);
    pressed[SLOT_UR] = act[SW_UR_BTN];
    pressed[SLOT_UL] = act[SW_UL_BTN] || (regs.gun_handles && act[SW_LL_BTN]);
    eos[SLOT_LR]     = act[SW_LR_EOS];
    eos[SLOT_LL]     = act[SW_LL_EOS];
    eos[SLOT_UR]     = act[SW_UR_EOS];
    eos[SLOT_UL]     = act[SW_UL_EOS];
    present[SLOT_LR] = 1'b1;
    present[SLOT_LL] = 1'b1;
    present[SLOT_UR] = regs.ur_present;
    present[SLOT_UL] = regs.ul_present;
  end

  for (genvar g = 0; g < NUM_FLIP; g++) begin : g_flip
    assign ctl[g].step      = adv;
    assign ctl[g].clear_all = clear_all;
    assign ctl[g].serve     = regs.flippers_on && act_any && present[g];
    assign ctl[g].pressed   = pressed[g];
    assign ctl[g].eos       = eos[g];

    fcphc_flip u_flip (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl[g]),
      .power_limit (regs.power_limit),
      .coil        (coil[g])
    );
  end

  always_comb begin
    drive = extra;
    for (int i = 0; i < NUM_FLIP; i++) begin
      drive[2*i]   = drive[2*i]   | coil[i].power;
      drive[2*i+1] = drive[2*i+1] | coil[i].hold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= drive;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FCPHC_ASSERT_NEXT(a_adv_fills_out, adv, out_tvalid, "evaluated item did not reach output")
  `FCPHC_ASSERT_NOW(a_full_blocks_in, stg_valid_r && out_valid_r && !out_tready, !in_tready, "input taken while pipeline blocked")
  `FCPHC_ASSERT_NEXT(a_off_passes_extra, adv && !regs.flippers_on, out_tdata == $past(extra), "disabled output differs from extra bits")
  `FCPHC_ASSERT_NEXT(a_idle_passes_extra, adv && clear_all, out_tdata == $past(extra), "no-input output differs from extra bits")

endmodule

/* design/fcphc_cfg.sv */
// Configuration register file
module fcphc_cfg
  import fcphc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.flippers_on <= 1'b0;
      regs_r.power_limit <= LIMIT_RST;
      regs_r.gun_handles <= 1'b0;
      regs_r.ul_present  <= 1'b0;
      regs_r.ur_present  <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_FLIPPERS_ON: regs_r.flippers_on <= cfg_data[0];
        REG_POWER_LIMIT: regs_r.power_limit <= cfg_data[CNT_W-1:0];
        REG_GUN_HANDLES: regs_r.gun_handles <= cfg_data[0];
        REG_UL_PRESENT:  regs_r.ul_present  <= cfg_data[0];
        REG_UR_PRESENT:  regs_r.ur_present  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* design/fcphc_flip.sv */
// One flipper: power counter and power/hold decision
module fcphc_flip
  import fcphc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  flip_ctl_t        ctl,
  input  logic [CNT_W-1:0] power_limit,
  output coil_pair_t       coil
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             full_pwr;

  assign full_pwr = !(ctl.eos || (cnt_r > power_limit));

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.clear_all) begin
      cnt_nxt = '0;
    end else if (ctl.serve) begin
      if (!ctl.pressed) begin
        cnt_nxt = '0;
      end else if (full_pwr && (cnt_r != CNT_MAX)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    coil.hold  = ctl.serve && ctl.pressed;
    coil.power = ctl.serve && ctl.pressed && full_pwr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.step) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
